// File: sv/slwm_pkg.sv
// Package with shared constants and types for the SQL LIKE wildcard matcher.
`timescale 1ns / 1ps

package slwm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int MAX_SUBJECT = 256;

    localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_CW = $clog2(MAX_PATTERN + 1);
    localparam int SUB_AW = (MAX_SUBJECT > 1) ? $clog2(MAX_SUBJECT) : 1;
    localparam int SUB_CW = $clog2(MAX_SUBJECT + 1);

    localparam logic [7:0] PCT_BYTE = 8'h25;
    localparam logic [7:0] UND_BYTE = 8'h5F;

    localparam logic [1:0] MODE_PAT  = 2'd0;
    localparam logic [1:0] MODE_SUB  = 2'd1;
    localparam logic [1:0] MODE_EVAL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_PCT,
        OP_ADV,
        OP_BACK,
        OP_SKIP,
        OP_FAIL,
        OP_TAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic si_lt_slen;
        logic pi_lt_plen;
        logic p_is_pct;
        logic p_match;
        logic have_star;
        logic out_busy;
    } dp_status_t;

endpackage

// File: sv/slwm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module slwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/slwm_datapath.sv
// Datapath: pattern and subject stores, match indices and the result register.
`timescale 1ns / 1ps

module slwm_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  slwm_pkg::dp_cmd_t      cmd,
    output slwm_pkg::dp_status_t   status,
    input  logic [1:0]             in_mode,
    input  logic [7:0]             in_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_matched,
    output logic                   out_overflow
);

    logic [slwm_pkg::PAT_CW-1:0] pat_count_reg, pat_count_next;
    logic [slwm_pkg::SUB_CW-1:0] sub_count_reg, sub_count_next;
    logic                        ovf_reg, ovf_next;
    logic [slwm_pkg::PAT_CW-1:0] pi_reg, pi_next;
    logic [slwm_pkg::SUB_CW-1:0] si_reg, si_next;
    logic [slwm_pkg::SUB_CW-1:0] anchor_reg, anchor_next;
    logic [slwm_pkg::PAT_AW-1:0] star_reg, star_next;
    logic                        have_star_reg, have_star_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        matched_reg, matched_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic       pat_full, sub_full;
    logic       pat_we, sub_we;
    logic [7:0] p_byte, s_byte;

    assign pat_full = (pat_count_reg == slwm_pkg::PAT_CW'(slwm_pkg::MAX_PATTERN));
    assign sub_full = (sub_count_reg == slwm_pkg::SUB_CW'(slwm_pkg::MAX_SUBJECT));
    assign pat_we   = (cmd.op == slwm_pkg::OP_LOAD) && (in_mode == slwm_pkg::MODE_PAT)
                      && !pat_full;
    assign sub_we   = (cmd.op == slwm_pkg::OP_LOAD) && (in_mode == slwm_pkg::MODE_SUB)
                      && !sub_full;

    slwm_ram #(
        .WIDTH (8),
        .DEPTH (slwm_pkg::MAX_PATTERN)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_count_reg[slwm_pkg::PAT_AW-1:0]),
        .wdata (in_byte),
        .raddr (pi_reg[slwm_pkg::PAT_AW-1:0]),
        .rdata (p_byte)
    );

    slwm_ram #(
        .WIDTH (8),
        .DEPTH (slwm_pkg::MAX_SUBJECT)
    ) u_sub_ram (
        .clk   (clk),
        .we    (sub_we),
        .waddr (sub_count_reg[slwm_pkg::SUB_AW-1:0]),
        .wdata (in_byte),
        .raddr (si_reg[slwm_pkg::SUB_AW-1:0]),
        .rdata (s_byte)
    );

    always_comb
    begin
        status.si_lt_slen = (si_reg < sub_count_reg);
        status.pi_lt_plen = (pi_reg < pat_count_reg);
        status.p_is_pct   = (p_byte == slwm_pkg::PCT_BYTE);
        status.p_match    = (p_byte == slwm_pkg::UND_BYTE) || (p_byte == s_byte);
        status.have_star  = have_star_reg;
        status.out_busy   = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        pat_count_next = pat_count_reg;
        sub_count_next = sub_count_reg;
        ovf_next       = ovf_reg;
        pi_next        = pi_reg;
        si_next        = si_reg;
        anchor_next    = anchor_reg;
        star_next      = star_reg;
        have_star_next = have_star_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        out_ovf_next   = out_ovf_reg;

        case (cmd.op)
            slwm_pkg::OP_LOAD:
            begin
                if (in_mode == slwm_pkg::MODE_PAT)
                begin
                    if (pat_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        pat_count_next = pat_count_reg + 1'b1;
                    end
                end
                else if (in_mode == slwm_pkg::MODE_SUB)
                begin
                    if (sub_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        sub_count_next = sub_count_reg + 1'b1;
                    end
                end
            end
            slwm_pkg::OP_START:
            begin
                pi_next        = '0;
                si_next        = '0;
                anchor_next    = '0;
                have_star_next = 1'b0;
            end
            slwm_pkg::OP_PCT:
            begin
                have_star_next = 1'b1;
                star_next      = pi_reg[slwm_pkg::PAT_AW-1:0];
                anchor_next    = si_reg;
                pi_next        = pi_reg + 1'b1;
            end
            slwm_pkg::OP_ADV:
            begin
                pi_next = pi_reg + 1'b1;
                si_next = si_reg + 1'b1;
            end
            slwm_pkg::OP_BACK:
            begin
                // Retry the segment after the last percent one subject byte later.
                pi_next     = slwm_pkg::PAT_CW'(star_reg) + 1'b1;
                anchor_next = anchor_reg + 1'b1;
                si_next     = anchor_reg + 1'b1;
            end
            slwm_pkg::OP_SKIP:
            begin
                pi_next = pi_reg + 1'b1;
            end
            slwm_pkg::OP_FAIL, slwm_pkg::OP_TAIL:
            begin
                out_valid_next = 1'b1;
                matched_next   = (cmd.op == slwm_pkg::OP_TAIL)
                                 && (pi_reg == pat_count_reg) && !ovf_reg;
                out_ovf_next   = ovf_reg;
                pat_count_next = '0;
                sub_count_next = '0;
                ovf_next       = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_count_reg <= '0;
            sub_count_reg <= '0;
            ovf_reg       <= 1'b0;
            have_star_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pat_count_reg <= pat_count_next;
            sub_count_reg <= sub_count_next;
            ovf_reg       <= ovf_next;
            have_star_reg <= have_star_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg      <= pi_next;
        si_reg      <= si_next;
        anchor_reg  <= anchor_next;
        star_reg    <= star_next;
        matched_reg <= matched_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_matched  = matched_reg;
    assign out_overflow = out_ovf_reg;

endmodule

// File: sv/slwm_controller.sv
// Controller state machine that sequences loading and the backtracking match.
`timescale 1ns / 1ps

module slwm_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_mode,
    output logic                  in_ready,
    input  slwm_pkg::dp_status_t  status,
    output slwm_pkg::dp_cmd_t     cmd
);

    slwm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slwm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = slwm_pkg::OP_NONE;
        in_ready   = 1'b0;

        case (state_reg)
            slwm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == slwm_pkg::MODE_EVAL)
                    begin
                        cmd.op     = slwm_pkg::OP_START;
                        state_next = slwm_pkg::ST_FETCH;
                    end
                    else if (in_mode == slwm_pkg::MODE_PAT || in_mode == slwm_pkg::MODE_SUB)
                    begin
                        cmd.op = slwm_pkg::OP_LOAD;
                    end
                end
            end
            slwm_pkg::ST_FETCH:
            begin
                // The stores read the new indices during this cycle.
                state_next = slwm_pkg::ST_EXEC;
            end
            slwm_pkg::ST_EXEC:
            begin
                state_next = slwm_pkg::ST_FETCH;
                if (status.si_lt_slen)
                begin
                    if (status.pi_lt_plen && status.p_is_pct)
                    begin
                        cmd.op = slwm_pkg::OP_PCT;
                    end
                    else if (status.pi_lt_plen && status.p_match)
                    begin
                        cmd.op = slwm_pkg::OP_ADV;
                    end
                    else if (status.have_star)
                    begin
                        cmd.op = slwm_pkg::OP_BACK;
                    end
                    else if (status.out_busy)
                    begin
                        state_next = slwm_pkg::ST_EXEC;
                    end
                    else
                    begin
                        cmd.op     = slwm_pkg::OP_FAIL;
                        state_next = slwm_pkg::ST_IDLE;
                    end
                end
                else if (status.pi_lt_plen && status.p_is_pct)
                begin
                    cmd.op = slwm_pkg::OP_SKIP;
                end
                else if (status.out_busy)
                begin
                    state_next = slwm_pkg::ST_EXEC;
                end
                else
                begin
                    cmd.op     = slwm_pkg::OP_TAIL;
                    state_next = slwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slwm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sql_like_wildcard_matcher.sv
// Top level of the SQL LIKE wildcard matcher: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// The input channel (s_*) carries one byte per transfer. s_tuser selects the
// action: 0 appends the byte to the pattern, 1 appends it to the subject,
// 2 evaluates, 3 is ignored. Appends are accepted back to back; bytes beyond 64
// pattern or 256 subject entries are dropped and set the overflow flag.
// An evaluate transfer starts the greedy matcher, which backtracks to the
// most recent percent sign. Each matcher step is a store read followed by a
// decision, and the number of steps grows with subject length times pattern
// segment length in the worst case. s_tready stays low for the whole evaluation.
// The output channel (m_*) then carries one transfer: matched and overflow.
// Evaluating clears both stores and the overflow flag.
// The result sits in an output register, so loading can continue while it
// waits; if a previous result is still stalled when an evaluation ends, the
// matcher holds until the receiver takes it.
// Reset empties both stores, clears the flag and drops any pending result.
module sql_like_wildcard_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    slwm_pkg::dp_cmd_t    cmd;
    slwm_pkg::dp_status_t status;
    logic                 matched;
    logic                 overflow;

    slwm_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slwm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_mode      (s_tuser),
        .in_byte      (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_matched  (matched),
        .out_overflow (overflow)
    );

    assign m_tdata = {6'b0, overflow, matched};

endmodule

// File: test/testbench.sv
// Self-checking testbench for the SQL LIKE wildcard matcher stream block.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_CAP = 50;

    typedef struct packed {
        logic overflow;
        logic matched;
    } verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_DENSE
    } rx_style_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] char_code
    logic [1:0] s_tuser = 2'd0;    // [1:0] mode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] matched, [1] overflow, [7:2] zero

    // Our own copy of the matcher state, updated on every accepted transfer.
    logic [7:0] pat_bytes[$];
    logic [7:0] subj_bytes[$];
    logic       drop_seen = 1'b0;
    verdict_t   verdicts_due[$];
    verdict_t   got_verdict;

    int cycle_count = 0;
    int mismatches = 0;
    int counted_items = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit steady = 1'b0;

    sql_like_wildcard_matcher uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Greedy scan that falls back to the most recent percent sign.
    function automatic logic like_matches();
        int pi;
        int si;
        int anchor;
        int star;
        logic have_star;
        pi = 0;
        si = 0;
        anchor = 0;
        star = 0;
        have_star = 1'b0;
        while (si < subj_bytes.size())
        begin
            if (pi < pat_bytes.size() && pat_bytes[pi] == slwm_pkg::PCT_BYTE)
            begin
                have_star = 1'b1;
                star = pi;
                anchor = si;
                pi++;
            end
            else if (pi < pat_bytes.size() &&
                     (pat_bytes[pi] == slwm_pkg::UND_BYTE ||
                      pat_bytes[pi] == subj_bytes[si]))
            begin
                pi++;
                si++;
            end
            else if (have_star)
            begin
                pi = star + 1;
                anchor++;
                si = anchor;
            end
            else
            begin
                return 1'b0;
            end
        end
        while (pi < pat_bytes.size() && pat_bytes[pi] == slwm_pkg::PCT_BYTE)
            pi++;
        return pi == pat_bytes.size();
    endfunction

    task automatic mirror_item(input logic [1:0] mode, input logic [7:0] ch);
        verdict_t v;
        case (mode)
            slwm_pkg::MODE_PAT:
            begin
                counted_items++;
                if (pat_bytes.size() < slwm_pkg::MAX_PATTERN)
                    pat_bytes.push_back(ch);
                else
                    drop_seen = 1'b1;
            end
            slwm_pkg::MODE_SUB:
            begin
                counted_items++;
                if (subj_bytes.size() < slwm_pkg::MAX_SUBJECT)
                    subj_bytes.push_back(ch);
                else
                    drop_seen = 1'b1;
            end
            slwm_pkg::MODE_EVAL:
            begin
                counted_items++;
                v.matched = like_matches() && !drop_seen;
                v.overflow = drop_seen;
                verdicts_due.push_back(v);
                pat_bytes.delete();
                subj_bytes.delete();
                drop_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one item and waits for its transfer; gaps fall between bursts.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ch);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mirror_item(mode, ch);
    endtask

    task automatic send_text(input logic [1:0] mode, input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(mode, text[i]);
    endtask

    task automatic send_repeat(input logic [1:0] mode, input logic [7:0] ch, input int n);
        repeat (n) send_item(mode, ch);
    endtask

    task automatic run_case(input string pat, input string subj);
        send_text(slwm_pkg::MODE_PAT, pat);
        send_text(slwm_pkg::MODE_SUB, subj);
        send_item(slwm_pkg::MODE_EVAL, 8'($urandom));
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic logic [7:0] pattern_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return slwm_pkg::PCT_BYTE;
        if (roll < 40)
            return slwm_pkg::UND_BYTE;
        if (roll < 94)
            return roll[0] ? "a" : "b";
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] subject_char();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return $urandom_range(0, 1) ? "a" : "b";
    endfunction

    task automatic test_directed_cases();
        run_case("", "");
        run_case("", "x");
        run_case("%%", "");
        run_case("a_c", "aXc");
        run_case("%b", "aab");
        run_case("%", "%");
        run_case("A", "a");
        // Extreme byte values must compare exactly; mode 3 must leave no trace.
        send_item(slwm_pkg::MODE_PAT, 8'hFF);
        send_item(MODE_IGNORED, 8'hFF);
        send_item(slwm_pkg::MODE_SUB, 8'hFF);
        send_item(slwm_pkg::MODE_PAT, 8'h00);
        send_item(slwm_pkg::MODE_SUB, 8'h00);
        send_item(slwm_pkg::MODE_EVAL, 8'hFF);
    endtask

    task automatic test_store_limits();
        // Both stores exactly full: still a clean match.
        send_repeat(slwm_pkg::MODE_PAT, slwm_pkg::UND_BYTE, slwm_pkg::MAX_PATTERN - 2);
        send_item(slwm_pkg::MODE_PAT, slwm_pkg::PCT_BYTE);
        send_item(slwm_pkg::MODE_PAT, "z");
        send_repeat(slwm_pkg::MODE_SUB, "y", slwm_pkg::MAX_SUBJECT - 1);
        send_item(slwm_pkg::MODE_SUB, "z");
        send_item(slwm_pkg::MODE_EVAL, 8'h00);
        // One pattern byte too many: the match would hold but is forced low.
        send_repeat(slwm_pkg::MODE_PAT, slwm_pkg::PCT_BYTE, slwm_pkg::MAX_PATTERN + 1);
        send_text(slwm_pkg::MODE_SUB, "ab");
        send_item(slwm_pkg::MODE_EVAL, 8'h00);
        // One subject byte too many.
        send_item(slwm_pkg::MODE_PAT, slwm_pkg::PCT_BYTE);
        send_repeat(slwm_pkg::MODE_SUB, "y", slwm_pkg::MAX_SUBJECT + 1);
        send_item(slwm_pkg::MODE_EVAL, 8'h00);
        // The flag must be gone after the evaluation that reported it.
        run_case("", "");
    endtask

    task automatic test_result_backpressure();
        steady = 1'b1;
        hold_left = 400;
        repeat (8) run_case("a%", "ab");
        steady = 1'b0;
    endtask

    task automatic test_random_sequences();
        logic [7:0] pat_plan[$];
        logic [7:0] subj_plan[$];
        int target;
        int plen;
        int idx;
        target = counted_items + RANDOM_ITEMS;
        while (counted_items < target)
        begin
            // The opening stretch runs without sender gaps.
            steady = (counted_items < target - RANDOM_ITEMS + 120);
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
            else
            begin
                pat_plan.delete();
                subj_plan.delete();
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(0, 8);
                repeat (plen) pat_plan.push_back(pattern_char());
                if ($urandom_range(0, 1) == 0)
                begin
                    // Subject built to fit the pattern, sometimes with one bit spoiled.
                    foreach (pat_plan[i])
                    begin
                        if (pat_plan[i] == slwm_pkg::PCT_BYTE)
                            repeat ($urandom_range(0, 3)) subj_plan.push_back(subject_char());
                        else if (pat_plan[i] == slwm_pkg::UND_BYTE)
                            subj_plan.push_back(8'($urandom));
                        else
                            subj_plan.push_back(pat_plan[i]);
                    end
                    if (subj_plan.size() > 0 && $urandom_range(0, 4) == 0)
                    begin
                        idx = $urandom_range(0, subj_plan.size() - 1);
                        subj_plan[idx] = subj_plan[idx] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end
                else
                begin
                    repeat ($urandom_range(0, 12)) subj_plan.push_back(subject_char());
                end
                while (pat_plan.size() + subj_plan.size() > 0)
                begin
                    if (subj_plan.size() == 0 ||
                        (pat_plan.size() != 0 && $urandom_range(0, 1) == 0))
                        send_item(slwm_pkg::MODE_PAT, pat_plan.pop_front());
                    else
                        send_item(slwm_pkg::MODE_SUB, subj_plan.pop_front());
                    if ($urandom_range(0, 49) == 0)
                        send_item(MODE_IGNORED, 8'($urandom));
                end
                send_item(slwm_pkg::MODE_EVAL, 8'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    // Receiver: alternating stall styles, plus the long hold-off on request.
    initial
    begin
        int seg_left;
        rx_style_t style;
        seg_left = 0;
        style = RX_OPEN;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 64);
                end
                seg_left--;
                case (style)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                report_mismatch($sformatf("result 0x%02h with none expected", m_tdata));
            end
            else
            begin
                got_verdict = verdicts_due.pop_front();
                if (m_tdata[0] !== got_verdict.matched)
                    report_mismatch($sformatf("matched %b, expected %b",
                                              m_tdata[0], got_verdict.matched));
                if (m_tdata[1] !== got_verdict.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              m_tdata[1], got_verdict.overflow));
                if (m_tdata[7:2] !== 6'd0)
                    report_mismatch($sformatf("padding bits 0x%02h not zero", m_tdata[7:2]));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_store_limits();
        test_result_backpressure();
        test_random_sequences();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/slwm_pkg.sv
sv/slwm_ram.sv
sv/slwm_datapath.sv
sv/slwm_controller.sv
sv/sql_like_wildcard_matcher.sv
test/testbench.sv
